// ===== src/tdf_pkg.sv =====
// shared types and constants for the trial division factorizer
`default_nettype none

package tdf_pkg;

    // fixed widths of the item fields
    localparam int PORT_W = 64;
    localparam int EXP_W  = 6;
    localparam int CNT_W  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMALL,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_PUSH,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== src/trial_division_factorizer.sv =====
// trial division factorizer: one shared restoring divider under a small sequencer
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_value
//   m_      | out       | m_valid / m_ready  | m_prime, m_exponent, m_last
//
// each candidate passes a check state, a division in ST_DIV and an evaluate state;
// each time it divides, the remainder runs another division and evaluate, each factor a push;
// values 0 and 1 answer through ST_SMALL.
// aresetn is synchronous, active low; it clears the sequencer and the output and pending valid flags.
// s_ready is high only in idle; a stalled m_ready holds the sequencer at the next result.
`default_nettype none

module trial_division_factorizer #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_PRIMES  = 15
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire [tdf_pkg::PORT_W-1:0]  s_value,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [tdf_pkg::PORT_W-1:0] m_prime,
    output logic [tdf_pkg::EXP_W-1:0]  m_exponent,
    output logic                       m_last
);
    import tdf_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int CW  = VALUE_WIDTH / 2 + 1;
    localparam int SQW = VALUE_WIDTH + 2;
    localparam int DCW = $clog2(VALUE_WIDTH);

    state_t            state_reg, state_next;
    logic [VW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     cand_reg, cand_next;
    logic [SQW-1:0]    sq_reg, sq_next;
    logic [EXP_W-1:0]  mult_reg, mult_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [VW-1:0]     pend_prime_reg, pend_prime_next;
    logic [EXP_W-1:0]  pend_exp_reg, pend_exp_next;
    logic [VW-1:0]     fact_prime_reg, fact_prime_next;
    logic [EXP_W-1:0]  fact_exp_reg, fact_exp_next;
    logic              fact_tail_reg, fact_tail_next;
    logic [VW-1:0]     div_q_reg, div_q_next;
    logic [CW-1:0]     div_r_reg, div_r_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [VW-1:0]     m_prime_reg, m_prime_next;
    logic [EXP_W-1:0]  m_exp_reg, m_exp_next;
    logic              m_last_reg, m_last_next;

    logic              out_free;
    logic [CW:0]       div_shift;
    logic [CW+1:0]     div_diff;
    logic              div_ge;
    logic [CW-1:0]     cand_adv;
    logic [SQW-1:0]    sq_adv;
    logic [VW-1:0]     in_value;

    assign in_value = s_value[VW-1:0];

    // one restoring step of the shared divider
    assign div_shift = {div_r_reg, div_q_reg[VW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, cand_reg};
    assign div_ge    = !div_diff[CW+1];

    // next odd candidate and its square, kept by adding 4c + 4
    assign cand_adv = (cand_reg == CW'(2)) ? CW'(3) : cand_reg + CW'(2);
    assign sq_adv   = (cand_reg == CW'(2)) ? SQW'(9)
                    : sq_reg + SQW'({cand_reg, 2'b00}) + SQW'(4);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        cand_next       = cand_reg;
        sq_next         = sq_reg;
        mult_next       = mult_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        fact_prime_next = fact_prime_reg;
        fact_exp_next   = fact_exp_reg;
        fact_tail_next  = fact_tail_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_prime_next    = m_prime_reg;
        m_exp_next      = m_exp_reg;
        m_last_next     = m_last_reg;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    rem_next        = in_value;
                    cand_next       = CW'(2);
                    sq_next         = SQW'(4);
                    mult_next       = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    if (in_value < VW'(2)) begin
                        state_next = ST_SMALL;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SMALL: begin
                // zero or one: single item with exponent zero
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_prime_next = rem_reg;
                    m_exp_next   = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (sq_reg > SQW'(rem_reg)) begin
                    if (rem_reg > VW'(1)) begin
                        fact_prime_next = rem_reg;
                        fact_exp_next   = EXP_W'(1);
                        fact_tail_next  = 1'b1;
                        state_next      = ST_PUSH;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end else begin
                    div_q_next   = rem_reg;
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                div_q_next   = {div_q_reg[VW-2:0], div_ge};
                div_r_next   = div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCW'(VW - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (div_r_reg == '0) begin
                    // divides: keep the quotient and try the same candidate again
                    rem_next     = div_q_reg;
                    mult_next    = mult_reg + 1'b1;
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end else if (mult_reg != '0) begin
                    fact_prime_next = VW'(cand_reg);
                    fact_exp_next   = mult_reg;
                    fact_tail_next  = 1'b0;
                    state_next      = ST_PUSH;
                end else begin
                    cand_next  = cand_adv;
                    sq_next    = sq_adv;
                    mult_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_PUSH: begin
                // the held factor goes out once a newer one exists
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_prime_next = pend_prime_reg;
                        m_exp_next   = pend_exp_reg;
                        m_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_prime_next = fact_prime_reg;
                    pend_exp_next   = fact_exp_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    if (fact_tail_reg || cnt_reg == CNT_W'(MAX_PRIMES - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cand_next  = cand_adv;
                        sq_next    = sq_adv;
                        mult_next  = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_prime_next    = pend_prime_reg;
                    m_exp_next      = pend_exp_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            mult_reg       <= '0;
            cand_reg       <= CW'(2);
            rem_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            mult_reg       <= mult_next;
            cand_reg       <= cand_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg         <= sq_next;
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
        fact_prime_reg <= fact_prime_next;
        fact_exp_reg   <= fact_exp_next;
        fact_tail_reg  <= fact_tail_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        div_cnt_reg    <= div_cnt_next;
        m_prime_reg    <= m_prime_next;
        m_exp_reg      <= m_exp_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_prime    = PORT_W'(m_prime_reg);
    assign m_exponent = m_exp_reg;
    assign m_last     = m_last_reg;

    // error code only ever closes a run
    a_zero_exp_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_exponent == '0 |-> m_last)
        else $error("exponent zero item not marked last");

    // no factor is left behind between items
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("pending factor while idle");

    // the run never grows past the prime limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_PRIMES))
        else $error("factor count above limit");

    // a new item starts the division sequence from candidate two
    a_start_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> cand_reg == CW'(2))
        else $error("candidate not restarted");

endmodule

`default_nettype wire
